FILE: rtl/core/i4p_pkg.sv
// Shared constants, types and the per-sample source table of the 4x4 luma intra predictor.
`default_nettype none

package i4p_pkg;

  // Sample and block geometry
  localparam int SAMPLE_BITS = 8;
  localparam int BLK_N       = 4;
  localparam int NUM_TOP     = 2 * BLK_N;
  localparam int NUM_LEFT    = BLK_N;
  localparam int NUM_NBR     = 13;
  localparam int NUM_PIX     = BLK_N * BLK_N;
  localparam int TOP_W       = NUM_TOP * SAMPLE_BITS;
  localparam int LEFT_W      = NUM_LEFT * SAMPLE_BITS;
  localparam int ROWS_W      = 2 * BLK_N * SAMPLE_BITS;
  localparam int SUM_W       = SAMPLE_BITS + 2;

  // Padded edge line: L3 L3 L2 L1 L0 C T0..T7 T7
  localparam int EDGE_N     = NUM_NBR + 2;
  localparam int AVG2_N     = EDGE_N - 1;
  localparam int AVG3_N     = EDGE_N - 2;
  localparam int IDX_W      = $clog2(EDGE_N);
  localparam int LEFT0_IDX  = NUM_LEFT;
  localparam int CORNER_IDX = LEFT0_IDX + 1;
  localparam int TOP0_IDX   = CORNER_IDX + 1;

  // Prediction modes
  localparam int MODE_W     = 4;
  localparam int MODE_COUNT = 9;
  localparam logic [MODE_W-1:0] MODE_VERT  = 4'd0;
  localparam logic [MODE_W-1:0] MODE_HORIZ = 4'd1;
  localparam logic [MODE_W-1:0] MODE_DC    = 4'd2;
  localparam logic [MODE_W-1:0] MODE_DDL   = 4'd3;
  localparam logic [MODE_W-1:0] MODE_DDR   = 4'd4;
  localparam logic [MODE_W-1:0] MODE_VR    = 4'd5;
  localparam logic [MODE_W-1:0] MODE_HD    = 4'd6;
  localparam logic [MODE_W-1:0] MODE_VL    = 4'd7;
  localparam logic [MODE_W-1:0] MODE_HU    = 4'd8;
  localparam logic [MODE_W-1:0] MODE_MAX   = MODE_HU;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef sample_t [EDGE_N-1:0]   edge_t;
  typedef sample_t [AVG2_N-1:0]   avg2_t;
  typedef sample_t [AVG3_N-1:0]   avg3_t;

  localparam sample_t DC_DEFAULT = sample_t'(1 << (SAMPLE_BITS - 1));

  typedef enum logic [2:0] {
    SRC_ZERO,
    SRC_RAW,
    SRC_AVG2,
    SRC_AVG3,
    SRC_DC
  } src_kind_t;

  typedef struct packed {
    src_kind_t        kind;
    logic [IDX_W-1:0] idx;
  } src_sel_t;

  // Control that travels with each beat through the stages
  typedef struct packed {
    logic              valid;
    logic [MODE_W-1:0] mode;
  } stage_ctl_t;

  typedef struct packed {
    edge_t            nbrs;
    logic [SUM_W-1:0] top_sum;
    logic [SUM_W-1:0] left_sum;
    logic             left_avail;
    logic             top_avail;
  } prep_t;

  typedef struct packed {
    edge_t   nbrs;
    avg2_t   a2;
    avg3_t   a3;
    sample_t dc;
  } filt_t;

  // Source of sample (x,y) for a mode. AVG2 index i means avg2(e[i], e[i+1]);
  // AVG3 index i means the 1-2-1 filter centered on e[i+1].
  function automatic src_sel_t pick_src(input logic [MODE_W-1:0] mode, input int x,
                                        input int y);
    src_sel_t s;
    int       z;
    int       hx;
    int       hy;
    int       i;
    hx     = x >>> 1;
    hy     = y >>> 1;
    z      = 0;
    i      = 0;
    s.kind = SRC_ZERO;
    case (mode)
      MODE_VERT: begin
        s.kind = SRC_RAW;
        i      = TOP0_IDX + x;
      end
      MODE_HORIZ: begin
        s.kind = SRC_RAW;
        i      = LEFT0_IDX - y;
      end
      MODE_DC: begin
        s.kind = SRC_DC;
      end
      MODE_DDL: begin
        // bottom-right corner lands on the padded T7 copy
        s.kind = SRC_AVG3;
        i      = TOP0_IDX + x + y;
      end
      MODE_DDR: begin
        s.kind = SRC_AVG3;
        i      = LEFT0_IDX + x - y;
      end
      MODE_VR: begin
        z = 2 * x - y;
        if (z >= 0 && !z[0]) begin
          s.kind = SRC_AVG2;
          i      = CORNER_IDX + x - hy;
        end else if (z > 0) begin
          s.kind = SRC_AVG3;
          i      = LEFT0_IDX + x - hy;
        end else if (z == -1) begin
          s.kind = SRC_AVG3;
          i      = LEFT0_IDX;
        end else begin
          s.kind = SRC_AVG3;
          i      = CORNER_IDX - y;
        end
      end
      MODE_HD: begin
        z = 2 * y - x;
        if (z >= 0 && !z[0]) begin
          s.kind = SRC_AVG2;
          i      = LEFT0_IDX - y + hx;
        end else if (z > 0) begin
          s.kind = SRC_AVG3;
          i      = LEFT0_IDX - y + hx;
        end else if (z == -1) begin
          s.kind = SRC_AVG3;
          i      = LEFT0_IDX;
        end else begin
          s.kind = SRC_AVG3;
          i      = TOP0_IDX - 3 + x;
        end
      end
      MODE_VL: begin
        s.kind = y[0] ? SRC_AVG3 : SRC_AVG2;
        i      = TOP0_IDX + x + hy;
      end
      MODE_HU: begin
        z = x + 2 * y;
        if (z inside {0, 2, 4}) begin
          s.kind = SRC_AVG2;
          i      = LEFT0_IDX - 1 - y - hx;
        end else if (z inside {1, 3, 5}) begin
          // the last one folds onto the padded L3 copy
          s.kind = SRC_AVG3;
          i      = LEFT0_IDX - 2 - y - hx;
        end else begin
          s.kind = SRC_RAW;
          i      = 0;
        end
      end
      default: begin
        s.kind = SRC_ZERO;
      end
    endcase
    s.idx = IDX_W'(i);
    return s;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/i4p_ifs.sv
// Valid/ready channel interfaces for neighbor beats in and predicted blocks out.
`default_nettype none

interface i4p_in_if import i4p_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] pred_mode;
  logic [TOP_W-1:0]  top_samples;
  logic [LEFT_W-1:0] left_samples;
  sample_t           corner_sample;
  logic              left_avail;
  logic              top_avail;
  logic              top_right_avail;

  modport source (
    output valid, pred_mode, top_samples, left_samples, corner_sample,
           left_avail, top_avail, top_right_avail,
    input  ready
  );

  modport sink (
    input  valid, pred_mode, top_samples, left_samples, corner_sample,
           left_avail, top_avail, top_right_avail,
    output ready
  );
endinterface

interface i4p_out_if import i4p_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ROWS_W-1:0] upper_rows;
  logic [ROWS_W-1:0] lower_rows;
  logic              bad_mode;

  modport source (
    output valid, upper_rows, lower_rows, bad_mode,
    input  ready
  );

  modport sink (
    input  valid, upper_rows, lower_rows, bad_mode,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/core/i4p_prep.sv
// Stage 1: unpack neighbors, fill missing top-right, sum top and left rows.
`default_nettype none

module i4p_prep import i4p_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [MODE_W-1:0] pred_mode,
  input  wire logic [TOP_W-1:0]  top_samples,
  input  wire logic [LEFT_W-1:0] left_samples,
  input  wire sample_t           corner_sample,
  input  wire logic              left_avail,
  input  wire logic              top_avail,
  input  wire logic              top_right_avail,
  output stage_ctl_t             ctl,
  output prep_t                  data
);

  logic              valid;
  logic [MODE_W-1:0] mode;
  prep_t             data_next;

  // Build the padded edge line and the two row sums
  always_comb begin
    sample_t t [NUM_TOP];
    sample_t l [NUM_LEFT];
    logic    fill_tr;
    fill_tr = top_avail && !top_right_avail;
    for (int k = 0; k < NUM_TOP; k++) begin
      t[k] = top_samples[SAMPLE_BITS*k +: SAMPLE_BITS];
      if (fill_tr && k >= BLK_N) begin
        t[k] = top_samples[SAMPLE_BITS*(BLK_N-1) +: SAMPLE_BITS];
      end
    end
    for (int j = 0; j < NUM_LEFT; j++) begin
      l[j] = left_samples[SAMPLE_BITS*j +: SAMPLE_BITS];
    end

    data_next.top_sum  = '0;
    data_next.left_sum = '0;
    for (int k = 0; k < BLK_N; k++) begin
      data_next.top_sum  = data_next.top_sum + SUM_W'(t[k]);
      data_next.left_sum = data_next.left_sum + SUM_W'(l[k]);
    end

    data_next.nbrs[0] = l[NUM_LEFT-1];
    for (int j = 0; j < NUM_LEFT; j++) begin
      data_next.nbrs[LEFT0_IDX-j] = l[j];
    end
    data_next.nbrs[CORNER_IDX] = corner_sample;
    for (int k = 0; k < NUM_TOP; k++) begin
      data_next.nbrs[TOP0_IDX+k] = t[k];
    end
    data_next.nbrs[EDGE_N-1] = t[NUM_TOP-1];

    data_next.left_avail = left_avail;
    data_next.top_avail  = top_avail;
  end

  // Advance the valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  // Hold payload unless the stage advances
  always_ff @(posedge clk) begin
    if (en) begin
      mode <= pred_mode;
      data <= data_next;
    end
  end

  assign ctl.valid = valid;
  assign ctl.mode  = mode;

endmodule

`default_nettype wire

FILE: rtl/core/i4p_filter.sv
// Stage 2: two-tap and three-tap filters along the edge line, plus the DC value.
`default_nettype none

module i4p_filter import i4p_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       en,
  input  wire stage_ctl_t ctl_in,
  input  wire prep_t      data_in,
  output stage_ctl_t      ctl,
  output filt_t           data
);

  logic              valid;
  logic [MODE_W-1:0] mode;
  filt_t             data_next;

  // Filter every tap position and pick the DC fallback
  always_comb begin
    logic [SAMPLE_BITS:0]   s2;
    logic [SAMPLE_BITS+1:0] s3;
    logic [SUM_W:0]         s_both;
    logic [SUM_W-1:0]       s_left;
    logic [SUM_W-1:0]       s_top;
    data_next.nbrs = data_in.nbrs;
    for (int i = 0; i < AVG2_N; i++) begin
      s2 = {1'b0, data_in.nbrs[i]} + {1'b0, data_in.nbrs[i+1]} + 1'b1;
      data_next.a2[i] = s2[SAMPLE_BITS:1];
    end
    for (int i = 0; i < AVG3_N; i++) begin
      s3 = (SAMPLE_BITS+2)'(data_in.nbrs[i]) + {1'b0, data_in.nbrs[i+1], 1'b0}
         + (SAMPLE_BITS+2)'(data_in.nbrs[i+2]) + (SAMPLE_BITS+2)'(2);
      data_next.a3[i] = s3[SAMPLE_BITS+1:2];
    end

    s_both = (SUM_W+1)'(data_in.top_sum) + (SUM_W+1)'(data_in.left_sum) + (SUM_W+1)'(4);
    s_left = data_in.left_sum + SUM_W'(2);
    s_top  = data_in.top_sum + SUM_W'(2);
    if (data_in.left_avail && data_in.top_avail) begin
      data_next.dc = s_both[SUM_W:3];
    end else if (data_in.left_avail) begin
      data_next.dc = s_left[SUM_W-1:2];
    end else if (data_in.top_avail) begin
      data_next.dc = s_top[SUM_W-1:2];
    end else begin
      data_next.dc = DC_DEFAULT;
    end
  end

  // Advance the valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= ctl_in.valid;
    end
  end

  // Hold payload unless the stage advances
  always_ff @(posedge clk) begin
    if (en) begin
      mode <= ctl_in.mode;
      data <= data_next;
    end
  end

  assign ctl.valid = valid;
  assign ctl.mode  = mode;

endmodule

`default_nettype wire

FILE: rtl/core/i4p_select.sv
// Stage 3: per-sample mode select into the output register.
`default_nettype none

module i4p_select import i4p_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       en,
  input  wire stage_ctl_t ctl_in,
  input  wire filt_t      data_in,
  output logic            valid,
  output logic [ROWS_W-1:0] upper_rows,
  output logic [ROWS_W-1:0] lower_rows,
  output logic            bad_mode
);

  sample_t [NUM_PIX-1:0] pix;

  // Each sample picks from fixed taps, one per mode
  for (genvar p = 0; p < NUM_PIX; p++) begin : g_pos
    sample_t cand [MODE_COUNT];

    for (genvar m = 0; m < MODE_COUNT; m++) begin : g_mode
      localparam src_sel_t SEL = pick_src(MODE_W'(m), p % BLK_N, p / BLK_N);
      if (SEL.kind == SRC_RAW) begin : g_raw
        assign cand[m] = data_in.nbrs[SEL.idx];
      end else if (SEL.kind == SRC_AVG2) begin : g_avg2
        assign cand[m] = data_in.a2[SEL.idx];
      end else if (SEL.kind == SRC_AVG3) begin : g_avg3
        assign cand[m] = data_in.a3[SEL.idx];
      end else if (SEL.kind == SRC_DC) begin : g_dc
        assign cand[m] = data_in.dc;
      end else begin : g_zero
        assign cand[m] = '0;
      end
    end

    always_comb begin
      if (ctl_in.mode <= MODE_MAX) begin
        pix[p] = cand[ctl_in.mode];
      end else begin
        pix[p] = '0;
      end
    end
  end

  // Advance the valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= ctl_in.valid;
    end
  end

  // Hold the result beat until taken
  always_ff @(posedge clk) begin
    if (en) begin
      upper_rows <= pix[NUM_PIX/2-1:0];
      lower_rows <= pix[NUM_PIX-1:NUM_PIX/2];
      bad_mode   <= ctl_in.mode > MODE_MAX;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/intra4x4_luma_predictor_top.sv
// Top level of the 4x4 luma intra predictor: three-stage pipeline and its stall chain.
`default_nettype none

// Takes the 13 neighbor samples of one 4x4 luma block with availability flags and a
// mode (0..8) per beat and returns the 16 predicted samples, one block per clock unless
// the output stalls, passing unpack and sum, filter and select into the output register.
// Every stage holds a valid bit and moves only when the stage after it is empty or
// moving, so nbr.ready follows pred.ready combinationally through the three stages and
// up to three beats are held while the output is stalled. A mode above 8 returns zero
// samples with bad_mode set.
module intra4x4_luma_predictor_top import i4p_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  i4p_in_if.sink    nbr,
  i4p_out_if.source pred
);

  stage_ctl_t prep_ctl;
  prep_t      prep_data;
  stage_ctl_t filt_ctl;
  filt_t      filt_data;
  logic       en_prep;
  logic       en_filt;
  logic       en_sel;

  // Stall chain: a stage loads when it is empty or its contents move on
  assign en_sel    = !pred.valid || pred.ready;
  assign en_filt   = !filt_ctl.valid || en_sel;
  assign en_prep   = !prep_ctl.valid || en_filt;
  assign nbr.ready = en_prep;

  i4p_prep u_prep (
    .clk             (clk),
    .rst             (rst),
    .en              (en_prep),
    .in_valid        (nbr.valid),
    .pred_mode       (nbr.pred_mode),
    .top_samples     (nbr.top_samples),
    .left_samples    (nbr.left_samples),
    .corner_sample   (nbr.corner_sample),
    .left_avail      (nbr.left_avail),
    .top_avail       (nbr.top_avail),
    .top_right_avail (nbr.top_right_avail),
    .ctl             (prep_ctl),
    .data            (prep_data)
  );

  i4p_filter u_filter (
    .clk     (clk),
    .rst     (rst),
    .en      (en_filt),
    .ctl_in  (prep_ctl),
    .data_in (prep_data),
    .ctl     (filt_ctl),
    .data    (filt_data)
  );

  i4p_select u_select (
    .clk        (clk),
    .rst        (rst),
    .en         (en_sel),
    .ctl_in     (filt_ctl),
    .data_in    (filt_data),
    .valid      (pred.valid),
    .upper_rows (pred.upper_rows),
    .lower_rows (pred.lower_rows),
    .bad_mode   (pred.bad_mode)
  );

`ifndef ASSERT_OFF
  // Input stalls only when every stage is full and the output is blocked
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !nbr.ready |-> (prep_ctl.valid && filt_ctl.valid && pred.valid && !pred.ready))
    else $error("input stalled with a free pipeline slot");

  // A new result comes only from a beat held in the filter stage
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(pred.valid) |-> $past(filt_ctl.valid))
    else $error("output valid without a beat in the filter stage");

  // A bad mode gives all-zero samples
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (pred.valid && pred.bad_mode) |-> (pred.upper_rows == '0 && pred.lower_rows == '0))
    else $error("bad mode with nonzero samples");
`endif

endmodule

`default_nettype wire
